// ===== design/mesh_index_dedup_fan_triangulator_core_macros.svh =====
// Assertion macros for the mesh index dedup core.
// Included by the top level; no other dependencies.
`ifndef MESH_INDEX_DEDUP_FAN_TRIANGULATOR_CORE_MACROS_SVH
`define MESH_INDEX_DEDUP_FAN_TRIANGULATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MIDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");
`define MIDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");
`else
`define MIDF_ASSERT_IMP(label, ante, cons)
`define MIDF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/midf_pkg.sv =====
// Shared types and constants for the mesh index dedup core.
// No dependencies.
package midf_pkg;
  localparam int TableEntries = 4096;
  localparam int TabBits = 12;
  localparam int MaxCorners = 7;
  localparam int CornBits = 3;
  localparam int RefBits = 24;
  localparam int IdxBits = 23;

  typedef enum logic [2:0] {
    OP_POS = 3'd0, OP_NRM = 3'd1, OP_TEX = 3'd2, OP_CORNER = 3'd3, OP_END = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    K_VERTEX = 3'd0, K_TRI = 3'd1, K_MANY = 3'd2, K_FEW = 3'd3,
    K_BADREF = 3'd4, K_FULL = 3'd5, K_HALT = 3'd6
  } kind_e;

  typedef struct packed {
    logic [2:0] op;
    logic signed [RefBits-1:0] position_ref;
    logic signed [RefBits-1:0] normal_ref;
    logic signed [RefBits-1:0] texcoord_ref;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [IdxBits-1:0] first;
    logic [IdxBits-1:0] second;
    logic [IdxBits-1:0] third;
    logic [TabBits-1:0] unique_index;
    logic last;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RESOLVE, S_HASH, S_READ, S_CMP, S_FAN, S_EMIT, S_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;  // write one invalid slot during clearing sweep
    logic load;        // capture input item
    logic resolve;     // resolve refs, range check
    logic hash;        // compute home slot
    logic read;        // issue table read at probe slot
    logic probe_next;  // advance probe
    logic insert;      // write new triple
    logic reuse;       // buffer known index
    logic declare;     // bump a count
    logic fan_init;    // start fan
    logic fan_next;    // advance fan
    logic set_err;     // build error result with err_kind
    logic [2:0] err_kind;
    logic set_vertex;
    logic set_tri;
    logic clear_corners;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic [2:0] op;
    logic bad_ref;
    logic corners_full;
    logic slot_empty;
    logic slot_match;
    logic probe_wrapped;
    logic table_full;
    logic few;
    logic fan_last;
  } stat_t;
endpackage

// ===== design/midf_datapath.sv =====
// Datapath: counters, resolver, hash table memory, corner buffer, result register.
// Depends on midf_pkg.
module midf_datapath (
  input  logic clk,
  input  logic rst,
  input  midf_pkg::in_t in_item,
  input  midf_pkg::cmd_t cmd,
  output midf_pkg::stat_t stat,
  output midf_pkg::out_t res
);
  import midf_pkg::*;

  localparam logic [RefBits-1:0] Cap = {1'b1, {(RefBits-1){1'b0}}};
  // hash multipliers, only the slot-index bits matter
  localparam logic [TabBits-1:0] HashP = TabBits'(32'd2654435761);
  localparam logic [TabBits-1:0] HashN = TabBits'(32'd40503);
  localparam logic [TabBits-1:0] HashT = TabBits'(32'd97);

  logic [RefBits-1:0] pos_cnt, nrm_cnt, tex_cnt;
  in_t item;
  logic signed [RefBits:0] p_r, n_r, t_r;
  logic [IdxBits-1:0] p, n, t;
  logic bad;
  logic [TabBits-1:0] slot, home;
  logic [TabBits:0] probes;
  logic [TabBits:0] uniq;
  logic [TabBits-1:0] clr_addr;
  logic clr_done;

  // table memory: {valid, p, n, t, dense}
  localparam int EntW = 1 + 3*IdxBits + TabBits;
  logic [EntW-1:0] mem [TableEntries];
  logic [EntW-1:0] rd;

  logic [TabBits-1:0] corners [MaxCorners];
  logic [CornBits-1:0] ccount;
  logic [CornBits-1:0] fan_i;

  always_comb begin
    logic signed [RefBits:0] pr, nr, tr;
    pr = {item.position_ref[RefBits-1], item.position_ref};
    nr = {item.normal_ref[RefBits-1], item.normal_ref};
    tr = {item.texcoord_ref[RefBits-1], item.texcoord_ref};
    p_r = pr[RefBits] ? pr + $signed({1'b0, pos_cnt}) : pr - (RefBits+1)'(1);
    n_r = nr[RefBits] ? nr + $signed({1'b0, nrm_cnt}) : nr;
    t_r = tr[RefBits] ? tr + $signed({1'b0, tex_cnt}) : tr;
  end

  // home slot from the registered resolved indices
  assign home = (p[TabBits-1:0] * HashP) ^ (n[TabBits-1:0] * HashN) ^
                (t[TabBits-1:0] * HashT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
      nrm_cnt <= RefBits'(1);
      tex_cnt <= RefBits'(1);
      uniq <= '0;
      ccount <= '0;
      clr_addr <= '0;
      clr_done <= 1'b0;
      res <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == TabBits'(TableEntries-1)) clr_done <= 1'b1;
      end
      if (cmd.declare) begin
        unique case (item.op)
          OP_POS: if (pos_cnt != Cap) pos_cnt <= pos_cnt + 1'b1;
          OP_NRM: if (nrm_cnt != Cap) nrm_cnt <= nrm_cnt + 1'b1;
          default: if (tex_cnt != Cap) tex_cnt <= tex_cnt + 1'b1;
        endcase
      end
      if (cmd.insert) begin
        uniq <= uniq + 1'b1;
        corners[ccount] <= uniq[TabBits-1:0];
        ccount <= ccount + 1'b1;
      end
      if (cmd.reuse) begin
        corners[ccount] <= rd[TabBits-1:0];
        ccount <= ccount + 1'b1;
      end
      if (cmd.clear_corners) ccount <= '0;
      if (cmd.set_err) res <= '{kind: cmd.err_kind, first: '0, second: '0, third: '0,
                                unique_index: '0, last: 1'b1};
      if (cmd.set_vertex) res <= '{kind: K_VERTEX, first: p, second: n, third: t,
                                   unique_index: uniq[TabBits-1:0], last: 1'b1};
      if (cmd.set_tri)
        res <= '{kind: K_TRI, first: IdxBits'(corners[0]),
                 second: IdxBits'(corners[fan_i - 1'b1]),
                 third: IdxBits'(corners[fan_i]), unique_index: '0,
                 last: (fan_i == ccount - 1'b1)};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.resolve) begin
      p <= p_r[IdxBits-1:0];
      n <= n_r[IdxBits-1:0];
      t <= t_r[IdxBits-1:0];
      bad <= p_r[RefBits] || (p_r >= $signed({1'b0, pos_cnt})) ||
             n_r[RefBits] || (n_r >= $signed({1'b0, nrm_cnt})) ||
             t_r[RefBits] || (t_r >= $signed({1'b0, tex_cnt}));
    end
    if (cmd.hash) begin
      slot <= home;
      probes <= '0;
    end
    if (cmd.probe_next) begin
      slot <= slot + 1'b1;
      probes <= probes + 1'b1;
    end
    if (cmd.fan_init) fan_i <= CornBits'(2);
    if (cmd.fan_next) fan_i <= fan_i + 1'b1;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) mem[clr_addr] <= '0;
    else if (cmd.insert) mem[slot] <= {1'b1, p, n, t, uniq[TabBits-1:0]};
    if (cmd.read) rd <= mem[slot];
  end

  always_comb begin
    stat.clear_done = clr_done;
    stat.op = item.op;
    stat.bad_ref = bad;
    stat.corners_full = (ccount == CornBits'(MaxCorners));
    stat.slot_empty = !rd[EntW-1];
    stat.slot_match = rd[EntW-2 -: 3*IdxBits] == {p, n, t};
    stat.probe_wrapped = (probes == (TabBits+1)'(TableEntries-1));
    stat.table_full = (uniq == (TabBits+1)'(TableEntries));
    stat.few = (ccount < CornBits'(3));
    stat.fan_last = (fan_i == ccount - 1'b1);
  end
endmodule

// ===== design/midf_control.sv =====
// Controller state machine for the mesh index dedup core.
// Depends on midf_pkg.
module midf_control (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  output logic res_valid,
  input  logic res_stall,
  input  midf_pkg::stat_t stat,
  output midf_pkg::cmd_t cmd
);
  import midf_pkg::*;

  state_t state, state_next;
  logic halted, halted_next;
  logic rv, rv_next;

  assign stall = (state != S_IDLE) || (rv && res_stall);
  assign res_valid = rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      halted <= 1'b0;
      rv <= 1'b0;
    end else begin
      state <= state_next;
      halted <= halted_next;
      rv <= rv_next;
    end
  end

  wire take = (state == S_IDLE) && valid && !(rv && res_stall);
  wire out_free = !rv || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:    if (take) state_next = S_RESOLVE;
      S_RESOLVE: begin
        priority if (halted) state_next = S_IDLE;
        else if (stat.op == OP_CORNER) state_next = S_HASH;
        else if (stat.op == OP_END) state_next = S_FAN;
        else state_next = S_IDLE;
      end
      S_HASH:    state_next = S_READ;
      S_READ:    state_next = S_CMP;
      S_CMP: begin
        priority if (stat.bad_ref || stat.corners_full) state_next = S_IDLE;
        else if (stat.slot_empty || stat.slot_match || stat.probe_wrapped)
          state_next = S_IDLE;
        else state_next = S_READ;
      end
      S_FAN:     state_next = S_IDLE;
      S_EMIT:    if (out_free && stat.fan_last) state_next = S_IDLE;
      S_WAIT:    state_next = S_EMIT;
      default:   state_next = S_IDLE;
    endcase
    if (state == S_FAN && !stat.few) state_next = S_WAIT;
  end

  always_comb begin
    cmd = '0;
    halted_next = halted;
    rv_next = rv && res_stall;
    unique case (state)
      S_CLEAR: cmd.clear_step = !stat.clear_done;
      S_IDLE:  cmd.load = take;
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        priority if (halted) begin
          cmd.set_err = 1'b1; cmd.err_kind = K_HALT; rv_next = 1'b1;
        end else if (stat.op == OP_POS || stat.op == OP_NRM || stat.op == OP_TEX)
          cmd.declare = 1'b1;
        else begin
        end
      end
      S_HASH: cmd.hash = 1'b1;
      S_READ: cmd.read = 1'b1;
      S_CMP: begin
        priority if (stat.bad_ref) begin
          cmd.set_err = 1'b1; cmd.err_kind = K_BADREF; rv_next = 1'b1; halted_next = 1'b1;
        end else if (stat.corners_full) begin
          cmd.set_err = 1'b1; cmd.err_kind = K_MANY; rv_next = 1'b1; halted_next = 1'b1;
        end else if (stat.slot_empty) begin
          if (stat.table_full) begin
            cmd.set_err = 1'b1; cmd.err_kind = K_FULL; halted_next = 1'b1;
          end else begin
            cmd.insert = 1'b1; cmd.set_vertex = 1'b1;
          end
          rv_next = 1'b1;
        end else if (stat.slot_match) cmd.reuse = 1'b1;
        else if (stat.probe_wrapped) begin
          cmd.set_err = 1'b1; cmd.err_kind = K_FULL; rv_next = 1'b1; halted_next = 1'b1;
        end else cmd.probe_next = 1'b1;
      end
      S_FAN: begin
        if (stat.few) begin
          cmd.set_err = 1'b1; cmd.err_kind = K_FEW; rv_next = 1'b1; halted_next = 1'b1;
        end else cmd.fan_init = 1'b1;
      end
      S_WAIT: ;
      S_EMIT: begin
        if (out_free) begin
          cmd.set_tri = 1'b1; rv_next = 1'b1;
          if (stat.fan_last) cmd.clear_corners = 1'b1;
          else cmd.fan_next = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== design/mesh_index_dedup_fan_triangulator_core.sv =====
// Mesh face-corner deduplicator and fan triangulator. Declarations bump
// the position/normal/texcoord counts; each face corner resolves its
// references, probes a 4096-slot hash table linearly (reading each slot
// through the table's registered read port, then comparing) and reports
// triples seen for the first time with a fresh dense index. End of face
// emits one triangle per cycle while the receiver does not stall. Any
// error latches a halt; afterwards each transfer yields one halted result.
// After reset a clearing pass (one write per slot) sweeps the table before
// the first item is taken. One result register parts the two channels.
// Depends on midf_pkg, midf_control, midf_datapath and the macros header.
`include "mesh_index_dedup_fan_triangulator_core_macros.svh"
module mesh_index_dedup_fan_triangulator_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  midf_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output midf_pkg::out_t out_data
);
  import midf_pkg::*;

  cmd_t cmd;
  stat_t stat;

  midf_control u_ctrl (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .res_valid(out_valid),
    .res_stall(out_stall), .stat, .cmd
  );

  midf_datapath u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .res(out_data)
  );

  // a stalled result may not be overwritten
  `MIDF_ASSERT_IMP(a_no_overwrite, out_valid && out_stall,
                   !cmd.set_err && !cmd.set_vertex && !cmd.set_tri)
  // a non-triangle result (error or vertex) always carries last
  `MIDF_ASSERT_IMP(a_err_last, out_valid && out_data.kind != K_TRI, out_data.last)
  // an insert always produces a new-vertex result
  `MIDF_ASSERT_NEXT(a_insert_valid, cmd.insert, out_valid && out_data.kind == K_VERTEX)
endmodule

// ===== tb/tb.sv =====
// Self-checking bench for mesh_index_dedup_fan_triangulator_core: face-corner
// dedup, fan triangulation and halt behaviour, checked against an in-bench predictor.
// Depends on midf_pkg and the core RTL.
`timescale 1ns / 1ps

class mesh_scoreboard;
  midf_pkg::out_t pending_q[$];
  // predictor state
  longint pos_count, nrm_count, tex_count;
  bit slot_used[4096];
  longint slot_p[4096], slot_n[4096], slot_t[4096];
  int slot_dense[4096];
  int unique_count;
  int corner_buf[7];
  int corner_count;
  bit halted;
  int mismatches;
  int results_seen;

  function void reset_state();
    pos_count = 0; nrm_count = 1; tex_count = 1;
    foreach (slot_used[i]) slot_used[i] = 0;
    unique_count = 0; corner_count = 0; halted = 0;
  endfunction

  function void push(midf_pkg::kind_e k, longint a, longint b, longint c, int u, bit l);
    midf_pkg::out_t r;
    r.kind = k; r.first = a[22:0]; r.second = b[22:0]; r.third = c[22:0];
    r.unique_index = u[11:0]; r.last = l;
    pending_q = {pending_q, r};
  endfunction

  function void trip(midf_pkg::kind_e k);
    halted = 1;
    push(k, 0, 0, 0, 0, 1);
  endfunction

  function void bump(ref longint cnt);
    if (cnt < (64'd1 << 23)) cnt++;
  endfunction

  function longint resolve(longint r, longint cnt, bit one_based);
    if (r < 0) return cnt + r;
    return one_based ? r - 1 : r;
  endfunction

  // note an accepted input transfer and queue what it should cause
  function void note_input(midf_pkg::in_t it);
    longint p, n, t, h, s;
    bit done;
    if (halted) begin
      push(midf_pkg::K_HALT, 0, 0, 0, 0, 1);
      return;
    end
    case (it.op)
      midf_pkg::OP_POS: bump(pos_count);
      midf_pkg::OP_NRM: bump(nrm_count);
      midf_pkg::OP_TEX: bump(tex_count);
      midf_pkg::OP_CORNER: begin
        p = resolve(longint'(it.position_ref), pos_count, 1);
        n = resolve(longint'(it.normal_ref), nrm_count, 0);
        t = resolve(longint'(it.texcoord_ref), tex_count, 0);
        if (p < 0 || p >= pos_count || n < 0 || n >= nrm_count || t < 0 || t >= tex_count)
          trip(midf_pkg::K_BADREF);
        else if (corner_count >= 7)
          trip(midf_pkg::K_MANY);
        else begin
          h = ((p * 64'd2654435761) ^ (n * 64'd40503) ^ (t * 64'd97)) & 64'hFFF;
          done = 0;
          for (int i = 0; i < 4096 && !done; i++) begin
            s = (h + i) & 64'hFFF;
            if (!slot_used[s]) begin
              done = 1;
              if (unique_count >= 4096) trip(midf_pkg::K_FULL);
              else begin
                slot_used[s] = 1; slot_p[s] = p; slot_n[s] = n; slot_t[s] = t;
                slot_dense[s] = unique_count;
                corner_buf[corner_count++] = unique_count;
                push(midf_pkg::K_VERTEX, p, n, t, unique_count, 1);
                unique_count++;
              end
            end else if (slot_p[s] == p && slot_n[s] == n && slot_t[s] == t) begin
              done = 1;
              corner_buf[corner_count++] = slot_dense[s];
            end
          end
          if (!done) trip(midf_pkg::K_FULL);
        end
      end
      midf_pkg::OP_END: begin
        if (corner_count < 3) trip(midf_pkg::K_FEW);
        else begin
          for (int i = 2; i < corner_count; i++)
            push(midf_pkg::K_TRI, corner_buf[0], corner_buf[i-1], corner_buf[i], 0,
                 i + 1 == corner_count);
          corner_count = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(midf_pkg::out_t got);
    midf_pkg::out_t exp_r;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
    end
  endfunction
endclass

module tb;
  import midf_pkg::*;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;

  mesh_scoreboard sb;
  event hold_go;       // starts the long receiver stall
  bit hold_on;         // long receiver stall, timed in its own process
  bit sink_quiet;      // stretch with no receiver stalls
  int items_sent;

  mesh_index_dedup_fan_triangulator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // mostly no gap, some short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // one transfer on the input channel; the predictor sees it when accepted.
  // valid stays up after acceptance so back-to-back transfers need no gap;
  // a gap or a drain drops it.
  task automatic send(in_t it, bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  function automatic in_t mk(op_e op, int pr, int nr, int tr);
    in_t it;
    it.op = op;
    it.position_ref = RefBits'(pr);
    it.normal_ref = RefBits'(nr);
    it.texcoord_ref = RefBits'(tr);
    return it;
  endfunction

  function automatic in_t junk(logic [2:0] op);
    in_t it;
    it.op = op;
    it.position_ref = RefBits'($urandom);
    it.normal_ref = RefBits'($urandom);
    it.texcoord_ref = RefBits'($urandom);
    return it;
  endfunction

  // a well-formed face of 3..7 corners with valid (mostly reused) references
  task automatic good_face(int ncorn);
    int pr, nr, tr;
    for (int c = 0; c < ncorn; c++) begin
      if (sb.pos_count == 0) send(mk(OP_POS, 0, 0, 0), 1);
      case ($urandom_range(0, 3))
        0: pr = -$urandom_range(1, (sb.pos_count > 6) ? 6 : sb.pos_count);
        default: pr = $urandom_range(1, (sb.pos_count > 12) ? 12 : sb.pos_count);
      endcase
      nr = ($urandom_range(0, 2) == 0) ? -$urandom_range(1, sb.nrm_count)
                                       : $urandom_range(0, sb.nrm_count - 1);
      tr = ($urandom_range(0, 2) == 0) ? -$urandom_range(1, sb.tex_count)
                                       : $urandom_range(0, sb.tex_count - 1);
      send(mk(OP_CORNER, pr, nr, tr), 1);
    end
    send(mk(OP_END, 0, 0, 0), 1);
  endtask

  // long receiver hold-off, counted here in cycles
  initial begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (300) @(posedge clk);
    hold_on <= 1'b0;
  end

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (sink_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1; in_valid = 0; in_data = '0;
    sink_quiet = 0; items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: declarations, the largest fan, reuse, ignored ops
    for (int i = 0; i < 4; i++) send(mk(OP_POS, 0, 0, 0), 0);
    send(mk(OP_NRM, 0, 0, 0), 0);
    send(mk(OP_TEX, 0, 0, 0), 0);
    send(junk(3'd5), 0);
    send(junk(3'd7), 0);
    send(mk(OP_CORNER, 1, 0, 0), 0);
    send(mk(OP_CORNER, -1, -1, -1), 0);
    send(mk(OP_CORNER, 2, 1, 1), 0);
    send(mk(OP_CORNER, 1, 0, 0), 0);   // known triple, no result
    send(mk(OP_END, 0, 0, 0), 0);
    for (int i = 0; i < 7; i++) send(mk(OP_CORNER, 1 + (i % 4), i % 2, 0), 0);
    send(mk(OP_END, 0, 0, 0), 0);

    // long receiver hold-off while the sender keeps offering
    -> hold_go;
    good_face(7);
    good_face(5);
    wait_drain();

    // random: mostly well-formed faces interleaved with declarations
    sink_quiet = 0;
    while (items_sent < 400) begin
      if ($urandom_range(0, 24) == 0) sink_quiet = !sink_quiet;
      case ($urandom_range(0, 9))
        0: send(mk(op_e'($urandom_range(0, 2)), $urandom, $urandom, $urandom), 1);
        1: send(junk(3'($urandom_range(5, 7))), 1);
        default: good_face($urandom_range(3, 7));
      endcase
      if ($urandom_range(0, 40) == 0) wait_drain();
    end
    wait_drain();

    // error path latching a halt: too few corners, then halted answers for all ops
    send(mk(OP_CORNER, 1, 0, 0), 1);
    send(mk(OP_END, 0, 0, 0), 1);
    for (int i = 0; i < 8; i++) send(junk(3'(i)), 1);
    // extremes of every field while halted
    send(mk(OP_CORNER, 24'h7FFFFF, 24'h800000, 24'h7FFFFF), 1);
    send(mk(OP_CORNER, 24'h800000, 24'h7FFFFF, 24'h800000), 1);
    for (int i = 0; i < 40; i++) send(junk(3'($urandom_range(0, 7))), 1);

    wait_drain();
    $display("covered %0d input transfers, %0d results, %0d dense vertices",
             items_sent, sb.results_seen, sb.unique_count);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
